FILE: hw/rtl/sha1bs_pkg.sv
`timescale 1ns / 1ps
package sha1bs_pkg;
  localparam logic [31:0] H0 = 32'h67452301;
  localparam logic [31:0] H1 = 32'hEFCDAB89;
  localparam logic [31:0] H2 = 32'h98BADCFE;
  localparam logic [31:0] H3 = 32'h10325476;
  localparam logic [31:0] H4 = 32'hC3D2E1F0;
  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_POS = 6'd56;
  localparam logic OP_ABSORB = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_ROUND, ST_ADD, ST_PAD, ST_OUT
  } sha1bs_state_t;

  typedef struct packed {
    logic init_chain;
    logic start_block;
    logic do_round;
    logic add_chain;
    logic pad_write;
    logic out_load;
  } sha1bs_cmd_t;

  typedef struct packed {
    logic round_last;
    logic pad_last;
  } sha1bs_sts_t;

  function automatic logic [31:0] round_k(input logic [6:0] r);
    if (r < 7'd20) round_k = 32'h5A827999;
    else if (r < 7'd40) round_k = 32'h6ED9EBA1;
    else if (r < 7'd60) round_k = 32'h8F1BBCDC;
    else round_k = 32'hCA62C1D6;
  endfunction
endpackage

FILE: hw/rtl/sha1bs_datapath.sv
`timescale 1ns / 1ps
module sha1bs_datapath (
  input  logic clk,
  input  logic absorb,
  input  logic [7:0] data_byte,
  input  logic [5:0] wr_idx,
  input  logic [31:0] bits,
  input  logic pad_first,
  input  sha1bs_pkg::sha1bs_cmd_t cmd,
  output sha1bs_pkg::sha1bs_sts_t sts,
  output logic [31:0] digest_word0,
  output logic [31:0] digest_word1,
  output logic [31:0] digest_word2,
  output logic [31:0] digest_word3,
  output logic [31:0] digest_word4
);
  import sha1bs_pkg::*;

  logic [31:0] w [16];
  logic [31:0] h [5];
  logic [31:0] a, b, c, d, e;
  logic [6:0] rnd;
  logic [5:0] pad_idx;
  logic [31:0] f, wt, wnew, t, x;
  logic [3:0] wi;
  logic [7:0] pad_val;

  assign wnew = {x[30:0], x[31]};
  assign x = w[13] ^ w[8] ^ w[2] ^ w[0];
  assign wt = (rnd < 7'd16) ? w[rnd[3:0]] : wnew;
  assign wi = pad_idx[5:2];

  always_comb begin
    if (rnd < 7'd20) f = (b & c) | (~b & d);
    else if (rnd < 7'd40 || rnd >= 7'd60) f = b ^ c ^ d;
    else f = (b & c) | (b & d) | (c & d);
    t = {a[26:0], a[31:27]} + f + e + wt + round_k(rnd);
    if (pad_idx == wr_idx && pad_first) pad_val = PAD_BYTE;
    else if (pad_idx >= 6'd60 && !(pad_first && wr_idx >= LEN_POS))
      pad_val = bits[8*(3 - pad_idx[1:0]) +: 8];
    else pad_val = 8'd0;
  end

  assign sts.round_last = (rnd == 7'd79);
  assign sts.pad_last = (pad_idx == 6'd63);

  always_ff @(posedge clk) begin
    if (cmd.init_chain) begin
      h[0] <= H0; h[1] <= H1; h[2] <= H2; h[3] <= H3; h[4] <= H4;
    end
    if (absorb) w[wr_idx[5:2]][8*(3 - wr_idx[1:0]) +: 8] <= data_byte;
    if (cmd.start_block) begin
      rnd <= '0;
      pad_idx <= wr_idx;
      a <= h[0]; b <= h[1]; c <= h[2]; d <= h[3]; e <= h[4];
    end
    if (cmd.pad_write) begin
      w[wi][8*(3 - pad_idx[1:0]) +: 8] <= pad_val;
      pad_idx <= pad_idx + 6'd1;
    end
    if (cmd.do_round) begin
      a <= t; b <= a; c <= {b[1:0], b[31:2]}; d <= c; e <= d;
      rnd <= rnd + 7'd1;
      if (rnd >= 7'd16) begin
        for (int i = 0; i < 15; i++) w[i] <= w[i+1];
        w[15] <= wnew;
      end
    end
    if (cmd.add_chain) begin
      h[0] <= h[0] + a; h[1] <= h[1] + b; h[2] <= h[2] + c;
      h[3] <= h[3] + d; h[4] <= h[4] + e;
    end
    if (cmd.out_load) begin
      digest_word0 <= h[0]; digest_word1 <= h[1]; digest_word2 <= h[2];
      digest_word3 <= h[3]; digest_word4 <= h[4];
    end
  end
endmodule

FILE: hw/rtl/sha1bs_ctrl.sv
`timescale 1ns / 1ps
module sha1bs_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic op,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  input  sha1bs_pkg::sha1bs_sts_t sts,
  output sha1bs_pkg::sha1bs_cmd_t cmd,
  output logic absorb,
  output logic [5:0] wr_idx,
  output logic [31:0] bits,
  output logic pad_first
);
  import sha1bs_pkg::*;

  sha1bs_state_t state, state_next;
  logic [5:0] count;
  logic [31:0] nbytes;
  logic fin, second, take;

  assign in_stall = (state != ST_IDLE) || out_valid;
  assign take = in_valid && !in_stall;
  assign absorb = take && op == OP_ABSORB;
  assign wr_idx = count;
  assign bits = {nbytes[28:0], 3'b000};
  assign pad_first = !second;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (take && op == OP_FINISH) state_next = ST_PAD;
        else if (absorb && count == 6'd63) state_next = ST_ROUND;
      end
      ST_PAD: if (sts.pad_last) state_next = ST_ROUND;
      ST_ROUND: if (sts.round_last) state_next = ST_ADD;
      ST_ADD: begin
        if (!fin) state_next = ST_IDLE;
        else if (pad_first && count >= LEN_POS) state_next = ST_PAD;
        else state_next = ST_OUT;
      end
      ST_OUT: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.init_chain = rst || state == ST_OUT;
    cmd.start_block = (take && op == OP_FINISH) || (state == ST_PAD && sts.pad_last);
    cmd.pad_write = state == ST_PAD;
    cmd.do_round = state == ST_ROUND;
    cmd.add_chain = state == ST_ADD;
    cmd.out_load = state == ST_OUT;
    if (absorb && count == 6'd63) cmd.start_block = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE; count <= '0; nbytes <= '0; fin <= 1'b0;
      second <= 1'b0; out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (absorb) begin
        count <= count + 6'd1;
        nbytes <= nbytes + 32'd1;
      end
      if (take && op == OP_FINISH) begin
        fin <= 1'b1; second <= 1'b0;
      end
      if (state == ST_ADD && fin && pad_first && count >= LEN_POS) second <= 1'b1;
      if (state == ST_OUT) begin
        out_valid <= 1'b1; fin <= 1'b0; second <= 1'b0;
        count <= '0; nbytes <= '0;
      end
    end
  end
endmodule

FILE: hw/rtl/sha1_byte_stream_hasher_unit.sv
`timescale 1ns / 1ps
// absorb: bytes are taken while idle; every 64th byte starts a block of 80 rounds and a chain add
// finish: per block a pad sweep (from the bytes held to byte 63, all 64 for a second block) and
// the 80 rounds with the chain add, one or two blocks, then ST_OUT loads the digest
// the 80-round compression loop, one round per cycle, stalls input until a block is done
// rst (synchronous) loads the initial chaining words and clears counts
module sha1_byte_stream_hasher_unit (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic op,
  input  logic [7:0] data_byte,
  output logic out_valid,
  input  logic out_stall,
  output logic [31:0] digest_word0,
  output logic [31:0] digest_word1,
  output logic [31:0] digest_word2,
  output logic [31:0] digest_word3,
  output logic [31:0] digest_word4
);
  import sha1bs_pkg::*;

  sha1bs_cmd_t cmd;
  sha1bs_sts_t sts;
  logic absorb, pad_first;
  logic [5:0] wr_idx;
  logic [31:0] bits;

  sha1bs_ctrl u_ctrl (
    .clk, .rst, .in_valid, .op, .in_stall, .out_valid, .out_stall,
    .sts, .cmd, .absorb, .wr_idx, .bits, .pad_first
  );

  sha1bs_datapath u_dp (
    .clk, .absorb, .data_byte, .wr_idx, .bits, .pad_first, .cmd, .sts,
    .digest_word0, .digest_word1, .digest_word2, .digest_word3, .digest_word4
  );
endmodule

FILE: tb/sv/tb_sha1_byte_stream_hasher_unit.sv
`timescale 1ns / 1ps
module tb_sha1_byte_stream_hasher_unit;
  import sha1bs_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic op = OP_ABSORB;
  logic [7:0] data_byte = 8'd0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [31:0] digest_word0, digest_word1, digest_word2, digest_word3, digest_word4;

  typedef struct packed {
    logic op;
    logic [7:0] data;
  } request_t;

  request_t pending_q[$];
  logic [159:0] digest_q[$];

  logic [31:0] chain[5];
  logic [7:0] blk[64];
  int unsigned fill;
  logic [31:0] msg_len;

  int errors = 0;
  int digests_seen = 0;
  int requests_sent = 0;
  int idle_cycles = 0;
  int send_gap = 0;
  int recv_gap = 0;
  int long_hold = 0;
  bit hold_req = 0;
  bit pause_send = 0;

  sha1_byte_stream_hasher_unit dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .op(op),
    .data_byte(data_byte), .out_valid(out_valid), .out_stall(out_stall),
    .digest_word0(digest_word0), .digest_word1(digest_word1),
    .digest_word2(digest_word2), .digest_word3(digest_word3),
    .digest_word4(digest_word4)
  );

  always #2 clk = ~clk;

  function automatic logic [31:0] rol(input logic [31:0] x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  task automatic compress_block();
    logic [31:0] w[80];
    logic [31:0] a, b, c, d, e, f, t, k;
    for (int i = 0; i < 16; i++)
      w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
    for (int i = 16; i < 80; i++)
      w[i] = rol(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
    a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3]; e = chain[4];
    for (int i = 0; i < 80; i++) begin
      if (i < 20) begin
        f = (b & c) | (~b & d); k = 32'h5A827999;
      end else if (i < 40) begin
        f = b ^ c ^ d; k = 32'h6ED9EBA1;
      end else if (i < 60) begin
        f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC;
      end else begin
        f = b ^ c ^ d; k = 32'hCA62C1D6;
      end
      t = rol(a, 5) + f + e + w[i] + k;
      e = d; d = c; c = rol(b, 30); b = a; a = t;
    end
    chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d; chain[4] += e;
  endtask

  task automatic restart_message();
    chain[0] = H0; chain[1] = H1; chain[2] = H2; chain[3] = H3; chain[4] = H4;
    fill = 0;
    msg_len = 0;
  endtask

  task automatic hash_request(input request_t r);
    int unsigned idx;
    logic [31:0] bits;
    if (r.op == OP_ABSORB) begin
      blk[fill] = r.data;
      fill++;
      msg_len++;
      if (fill == 64) begin
        compress_block();
        fill = 0;
      end
    end else begin
      idx = fill;
      blk[idx] = PAD_BYTE;
      idx++;
      if (idx > LEN_POS) begin
        for (int i = idx; i < 64; i++) blk[i] = 8'd0;
        compress_block();
        idx = 0;
      end
      for (int i = idx; i < LEN_POS; i++) blk[i] = 8'd0;
      bits = msg_len * 8;
      for (int i = 56; i < 60; i++) blk[i] = 8'd0;
      {blk[60], blk[61], blk[62], blk[63]} = bits;
      compress_block();
      digest_q.push_back({chain[0], chain[1], chain[2], chain[3], chain[4]});
      restart_message();
    end
  endtask

  task automatic add_message(input int n, input bit rand_data, input logic [7:0] fixed);
    request_t r;
    for (int i = 0; i < n; i++) begin
      r.op = OP_ABSORB;
      r.data = rand_data ? 8'($urandom_range(0, 255)) : fixed;
      pending_q.push_back(r);
    end
    r.op = OP_FINISH;
    r.data = 8'($urandom_range(0, 255));
    pending_q.push_back(r);
  endtask

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        hash_request('{op: op, data: data_byte});
        requests_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_q.size() > 0 && !pause_send) begin
          in_valid <= 1'b1;
          {op, data_byte} <= pending_q.pop_front();
          send_gap <= pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    logic [159:0] exp_d;
    logic [159:0] got;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got = {digest_word0, digest_word1, digest_word2, digest_word3, digest_word4};
        digests_seen++;
        if (digest_q.size() == 0) begin
          $error("unexpected digest %h", got);
          errors++;
        end else begin
          exp_d = digest_q.pop_front();
          for (int i = 0; i < 5; i++)
            if (got[159-32*i -: 32] !== exp_d[159-32*i -: 32]) begin
              $error("digest_word%0d expected %h actual %h", i,
                     exp_d[159-32*i -: 32], got[159-32*i -: 32]);
              errors++;
            end
        end
      end
      if (hold_req && long_hold == 0) begin
        long_hold <= 400;
        out_stall <= 1'b1;
      end else if (long_hold > 0) begin
        long_hold <= long_hold - 1;
        out_stall <= (long_hold > 1);
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        recv_gap <= pick_gap();
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int sizes[9];
    int n;
    restart_message();
    for (int i = 0; i < 64; i++) blk[i] = 8'd0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: empty message, byte extremes, padding boundaries
    add_message(0, 0, 8'h00);
    add_message(1, 0, 8'hFF);
    add_message(3, 0, 8'h00);
    add_message(5, 1, 8'h00);
    wait (pending_q.size() == 0 && digest_q.size() == 0);
    sizes = '{55, 56, 63, 64, 65, 0, 1, 2, 57};
    foreach (sizes[i]) add_message(sizes[i], 1, 8'h00);

    // long receiver hold while the sender keeps offering
    hold_req = 1;
    wait (long_hold > 0);
    hold_req = 0;
    for (int i = 0; i < 4; i++) add_message(3, 1, 8'h00);

    // sender pauses until all digests are back
    wait (pending_q.size() == 0);
    pause_send = 1;
    wait (digest_q.size() == 0 && !in_valid);
    pause_send = 0;

    // random messages
    n = 0;
    while (n < 300) begin
      int len;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 140) : $urandom_range(0, 20);
      add_message(len, 1, 8'h00);
      n += len + 1;
    end

    wait (pending_q.size() == 0 && !in_valid);
    wait (digest_q.size() == 0);
    repeat (300) @(posedge clk);
    $display("requests hashed: %0d, digests checked: %0d", requests_sent, digests_seen);
    $display("covered empty and padding-boundary messages, stalls and long holds");
    if (errors == 0 && digest_q.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end
endmodule
